/* hw/rtl/tile_neighbor_match_mask_macros.svh */
// Assertion macros for the tile neighbour match mask checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TILE_NEIGHBOR_MATCH_MASK_MACROS_SVH
`define TILE_NEIGHBOR_MATCH_MASK_MACROS_SVH

// same-cycle implication, idle during reset
`define TNM_ASSERT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// next-cycle implication, idle during reset
`define TNM_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

/* hw/rtl/tnm_pkg.sv */
// Shared types, constants and the mask function of the tile neighbour match mask.
// No dependencies; used by every other file of the block but the macros header.
`timescale 1ns / 1ps

package tnm_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int STATE_W      = 2;
  localparam int MASK_W       = 8;
  localparam int COL_W        = 6;
  localparam int ROW_W        = 10;
  localparam int MAP_WIDTH_W  = 7;
  localparam int MAP_HEIGHT_W = 11;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_ADDR_W   = 1;

  localparam int MAP_WIDTH_RST  = 64;
  localparam int MAP_HEIGHT_RST = 1024;

  // result queue, power of two
  localparam int OUTQ_DEPTH = 4;

  // mask bit positions
  localparam int NB_UP = 0;
  localparam int NB_DN = 1;
  localparam int NB_LF = 2;
  localparam int NB_RT = 3;
  localparam int NB_UL = 4;
  localparam int NB_UR = 5;
  localparam int NB_DL = 6;
  localparam int NB_DR = 7;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } cfg_reg_t;

  // one column of the 3-row window: top is two rows above the newest row
  typedef struct packed {
    logic [STATE_W-1:0] top;
    logic [STATE_W-1:0] mid;
    logic [STATE_W-1:0] bot;
  } tcol_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [MASK_W-1:0] mask;
    logic              last;
    logic              done;
  } out_rec_t;

  // up to two results per accepted beat; v1 only with v0
  typedef struct packed {
    logic     v0;
    logic     v1;
    out_rec_t r0;
    out_rec_t r1;
  } push_t;

  // centre is cen.mid; neighbours off the map always match
  function automatic logic [MASK_W-1:0] mask_f(
    input tcol_t lft,
    input tcol_t cen,
    input tcol_t rgt,
    input logic  off_up,
    input logic  off_dn,
    input logic  off_lf,
    input logic  off_rt
  );
    logic [MASK_W-1:0]  m;
    logic [STATE_W-1:0] c;
    c         = cen.mid;
    m[NB_UP]  = off_up || (cen.top == c);
    m[NB_DN]  = off_dn || (cen.bot == c);
    m[NB_LF]  = off_lf || (lft.mid == c);
    m[NB_RT]  = off_rt || (rgt.mid == c);
    m[NB_UL]  = off_up || off_lf || (lft.top == c);
    m[NB_UR]  = off_up || off_rt || (rgt.top == c);
    m[NB_DL]  = off_dn || off_lf || (lft.bot == c);
    m[NB_DR]  = off_dn || off_rt || (rgt.bot == c);
    return m;
  endfunction

endpackage

/* hw/rtl/tnm_cell.sv */
// One 2-bit stage of a row delay line: takes its neighbour's value or the line
// input when it is the entry stage. Depends on tnm_pkg.
`timescale 1ns / 1ps

module tnm_cell (
  input  logic                        clk,
  input  logic                        shift,
  input  logic                        is_entry,
  input  logic [tnm_pkg::STATE_W-1:0] chain_in,
  input  logic [tnm_pkg::STATE_W-1:0] line_in,
  output logic [tnm_pkg::STATE_W-1:0] q
);

  logic [tnm_pkg::STATE_W-1:0] val_r;
  logic [tnm_pkg::STATE_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (shift) begin
      val_nxt = is_entry ? line_in : chain_in;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

/* hw/rtl/tnm_line.sv */
// Row delay line built from a chain of tnm_cell stages; its length equals the
// map width by choosing which stage takes the line input. Depends on tnm_pkg.
`timescale 1ns / 1ps

module tnm_line #(
  parameter int DEPTH = tnm_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        shift,
  input  logic [$clog2(DEPTH)-1:0]    entry_idx,
  input  logic [tnm_pkg::STATE_W-1:0] line_in,
  output logic [tnm_pkg::STATE_W-1:0] line_out,
  output logic [tnm_pkg::STATE_W-1:0] line_peek
);

  localparam int IW = $clog2(DEPTH);

  logic [tnm_pkg::STATE_W-1:0] stage [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [tnm_pkg::STATE_W-1:0] from_prev;
    if (k == 0) begin : g_head
      assign from_prev = line_in;
    end else begin : g_body
      assign from_prev = stage[k-1];
    end
    tnm_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .is_entry (entry_idx == IW'(k)),
      .chain_in (from_prev),
      .line_in  (line_in),
      .q        (stage[k])
    );
  end

  // output is the value w beats old, peek the one that follows it
  assign line_out  = stage[DEPTH-1];
  assign line_peek = stage[DEPTH-2];

endmodule

/* hw/rtl/tnm_out_q.sv */
// Small result queue: takes up to two results a cycle, gives one beat a cycle
// while the head is taken. Depends on tnm_pkg.
`timescale 1ns / 1ps

module tnm_out_q (
  input  logic              clk,
  input  logic              rst_n,
  input  tnm_pkg::push_t    push,
  output logic              room2,
  output logic              head_valid,
  input  logic              head_taken,
  output tnm_pkg::out_rec_t head
);

  localparam int DEPTH = tnm_pkg::OUTQ_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  tnm_pkg::out_rec_t mem [DEPTH];

  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic [1:0]    n_push;
  logic          pop;

  assign head_valid = (cnt_r != '0);
  assign room2      = (cnt_r <= (PW+1)'(DEPTH - 2));
  assign pop        = head_valid && head_taken;
  assign n_push     = {1'b0, push.v0} + {1'b0, push.v1};
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(n_push);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + (PW+1)'(n_push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_ptr_r + PW'(1)] <= push.r1;
    end
  end

endmodule

/* hw/rtl/tile_neighbor_match_mask.sv */
// Channel  | Beat holds                                   | Side
// in_      | tdata: tile_state[1:0]; tuser: kind          | slave
// out_     | tdata: mask[7:0] col[13:8] row[23:14];       | master
//          | tlast: last_in_run; tuser: map_done          |
// cfg_     | write enable, register index, data           | write only
// One input beat per cycle; a beat is taken while the result queue has two
// free entries, so the queue sets the pace when the result side stalls.
// A beat's results enter the queue at the edge that takes it and show on out_
// from the next cycle if the queue was empty; a row-closing beat below the first row
// gives two unless the map is one column wide. Synchronous reset, no clearing pass.
// Top level of the tile neighbour match mask; uses tnm_pkg, tnm_line, tnm_out_q.
`timescale 1ns / 1ps

module tile_neighbor_match_mask #(
  parameter int MAX_WIDTH  = tnm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tnm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [1:0] tile_state
  input  logic [0:0]                     in_tuser,   // [0] kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // [7:0] match_mask, [13:8] cell_column,
                                                     // [23:14] cell_row
  output logic                           out_tlast,
  output logic [0:0]                     out_tuser,  // [0] map_done
  input  logic                           cfg_we,
  input  logic [tnm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tnm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RST_W = (tnm_pkg::MAP_WIDTH_RST > MAX_WIDTH) ?
                         MAX_WIDTH : tnm_pkg::MAP_WIDTH_RST;
  localparam int RST_H = (tnm_pkg::MAP_HEIGHT_RST > MAX_HEIGHT) ?
                         MAX_HEIGHT : tnm_pkg::MAP_HEIGHT_RST;

  logic [CW-1:0] last_col_r, last_col_nxt;
  logic [RW-1:0] last_row_r, last_row_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] flush_col_r, flush_col_nxt;
  logic          draining_r, draining_nxt;

  tnm_pkg::tcol_t p1_r, p1_nxt;
  tnm_pkg::tcol_t p2_r, p2_nxt;
  tnm_pkg::tcol_t col_now, col_rgt;

  logic [31:0]   wv, hv;
  logic [CW-1:0] cfg_last_col;
  logic [RW-1:0] cfg_last_row;
  logic [CW-1:0] entry_idx;

  logic                        in_acc, is_flush, tile_go, flush_go, shift;
  logic [tnm_pkg::STATE_W-1:0] x;
  logic [tnm_pkg::STATE_W-1:0] a_out, a_peek, b_out, b_peek;
  logic                        first_up, v_a, v_b, flush_end;

  tnm_pkg::out_rec_t rec_a, rec_b, rec_f, head;
  tnm_pkg::push_t    push;
  logic              room2;

  // clamp register writes to 1..max and keep them as last index
  assign wv = 32'(cfg_wdata[tnm_pkg::MAP_WIDTH_W-1:0]);
  assign hv = 32'(cfg_wdata[tnm_pkg::MAP_HEIGHT_W-1:0]);

  always_comb begin
    if (wv == 32'd0) begin
      cfg_last_col = '0;
    end else if (wv > 32'(MAX_WIDTH)) begin
      cfg_last_col = CW'(MAX_WIDTH - 1);
    end else begin
      cfg_last_col = CW'(wv - 32'd1);
    end
    if (hv == 32'd0) begin
      cfg_last_row = '0;
    end else if (hv > 32'(MAX_HEIGHT)) begin
      cfg_last_row = RW'(MAX_HEIGHT - 1);
    end else begin
      cfg_last_row = RW'(hv - 32'd1);
    end
  end

  assign entry_idx = CW'(MAX_WIDTH - 1) - last_col_r;

  assign in_acc   = in_tvalid && in_tready;
  assign is_flush = in_tuser[0];
  assign tile_go  = in_acc && !is_flush && !draining_r;
  assign flush_go = in_acc && is_flush && draining_r;
  assign shift    = tile_go || flush_go;
  assign x        = in_tdata[tnm_pkg::STATE_W-1:0];

  // line A delays by one row, line B by two
  tnm_line #(.DEPTH(MAX_WIDTH)) u_line_a (
    .clk       (clk),
    .shift     (shift),
    .entry_idx (entry_idx),
    .line_in   (x),
    .line_out  (a_out),
    .line_peek (a_peek)
  );

  tnm_line #(.DEPTH(MAX_WIDTH)) u_line_b (
    .clk       (clk),
    .shift     (shift),
    .entry_idx (entry_idx),
    .line_in   (a_out),
    .line_out  (b_out),
    .line_peek (b_peek)
  );

  assign col_now = '{top: b_out, mid: a_out, bot: x};
  assign col_rgt = '{top: b_peek, mid: a_peek, bot: x};

  assign first_up  = (in_row_r == RW'(1));
  assign v_a       = (in_row_r != '0) && (in_col_r != '0);
  assign v_b       = (in_row_r != '0) && (in_col_r == last_col_r);
  assign flush_end = (flush_col_r == last_col_r);

  always_comb begin
    // cell one column back, one row up
    rec_a.mask = tnm_pkg::mask_f(p2_r, p1_r, col_now, first_up, 1'b0,
                                 in_col_r == CW'(1), 1'b0);
    rec_a.col  = tnm_pkg::COL_W'(in_col_r - CW'(1));
    rec_a.row  = tnm_pkg::ROW_W'(in_row_r - RW'(1));
    rec_a.last = !v_b;
    rec_a.done = 1'b0;
    // last cell of the row above
    rec_b.mask = tnm_pkg::mask_f(p1_r, col_now, col_now, first_up, 1'b0,
                                 in_col_r == '0, 1'b1);
    rec_b.col  = tnm_pkg::COL_W'(in_col_r);
    rec_b.row  = tnm_pkg::ROW_W'(in_row_r - RW'(1));
    rec_b.last = 1'b1;
    rec_b.done = 1'b0;
    // bottom row while draining
    rec_f.mask = tnm_pkg::mask_f(p1_r, col_now, col_rgt, last_row_r == '0, 1'b1,
                                 flush_col_r == '0, flush_end);
    rec_f.col  = tnm_pkg::COL_W'(flush_col_r);
    rec_f.row  = tnm_pkg::ROW_W'(last_row_r);
    rec_f.last = 1'b1;
    rec_f.done = flush_end;
  end

  always_comb begin
    push.v0 = 1'b0;
    push.v1 = 1'b0;
    push.r0 = rec_a;
    push.r1 = rec_b;
    if (flush_go) begin
      push.v0 = 1'b1;
      push.r0 = rec_f;
    end else if (tile_go) begin
      if (v_a) begin
        push.v0 = 1'b1;
        push.v1 = v_b;
      end else if (v_b) begin
        push.v0 = 1'b1;
        push.r0 = rec_b;
      end
    end
  end

  always_comb begin
    p1_nxt = shift ? col_now : p1_r;
    p2_nxt = shift ? p1_r : p2_r;
  end

  always_comb begin
    last_col_nxt  = last_col_r;
    last_row_nxt  = last_row_r;
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    flush_col_nxt = flush_col_r;
    draining_nxt  = draining_r;
    if (cfg_we) begin
      unique case (tnm_pkg::cfg_reg_t'(cfg_addr))
        tnm_pkg::REG_MAP_WIDTH:  last_col_nxt = cfg_last_col;
        tnm_pkg::REG_MAP_HEIGHT: last_row_nxt = cfg_last_row;
        default:                 last_col_nxt = last_col_r;
      endcase
      // any write restarts the map
      in_col_nxt    = '0;
      in_row_nxt    = '0;
      flush_col_nxt = '0;
      draining_nxt  = 1'b0;
    end else if (tile_go) begin
      if (in_col_r == last_col_r) begin
        in_col_nxt = '0;
        if (in_row_r == last_row_r) begin
          draining_nxt = 1'b1;
        end else begin
          in_row_nxt = in_row_r + RW'(1);
        end
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end else if (flush_go) begin
      if (flush_end) begin
        in_col_nxt    = '0;
        in_row_nxt    = '0;
        flush_col_nxt = '0;
        draining_nxt  = 1'b0;
      end else begin
        flush_col_nxt = flush_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r  <= CW'(RST_W - 1);
      last_row_r  <= RW'(RST_H - 1);
      in_col_r    <= '0;
      in_row_r    <= '0;
      flush_col_r <= '0;
      draining_r  <= 1'b0;
    end else begin
      last_col_r  <= last_col_nxt;
      last_row_r  <= last_row_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      flush_col_r <= flush_col_nxt;
      draining_r  <= draining_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
  end

  tnm_out_q u_out_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room2      (room2),
    .head_valid (out_tvalid),
    .head_taken (out_tready),
    .head       (head)
  );

  assign in_tready = room2;
  assign out_tdata = {head.row, head.col, head.mask};
  assign out_tlast = head.last;
  assign out_tuser = head.done;

endmodule

/* hw/rtl/tnm_check.sv */
// Port-level checker for the tile neighbour match mask, bound to the top level.
// Uses the assertion macros of tile_neighbor_match_mask_macros.svh.
`timescale 1ns / 1ps
`include "tile_neighbor_match_mask_macros.svh"

module tnm_check #(
  parameter int MAX_WIDTH = tnm_pkg::MAX_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);

  // column field is exact only while every column fits in it
  localparam bit COL_EXACT = (MAX_WIDTH <= 64);

  `TNM_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result beat changed")
  `TNM_ASSERT(a_done_last, out_tvalid && out_tuser[0], out_tlast, "map end beat without tlast")
  `TNM_ASSERT(a_done_edge, out_tvalid && out_tuser[0], out_tdata[1] && out_tdata[3] && out_tdata[5] && out_tdata[6] && out_tdata[7], "final cell mask lacks off-map bits")
  `TNM_ASSERT(a_col0_left, out_tvalid && COL_EXACT && (out_tdata[13:8] == 6'd0), out_tdata[2] && out_tdata[4] && out_tdata[6], "first column mask lacks left bits")

endmodule

bind tile_neighbor_match_mask tnm_check #(.MAX_WIDTH(MAX_WIDTH)) u_tnm_check (.*);

/* sim/tb_tile_neighbor_match_mask.sv */
// Self-checking testbench for tile_neighbor_match_mask: directed table, then random maps.
// Keeps its own copy of the map and predicts every mask; depends on tnm_pkg and the RTL.
`timescale 1ns / 1ps

module tb_tile_neighbor_match_mask;

  localparam int ITEMS_TARGET = 1950;
  localparam int GAP_PCT      = 32;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int MAP_COLS     = 64;
  localparam int MAP_ROWS     = 1024;
  localparam int PLAN_ROWS    = 29;

  localparam bit KIND_TILE  = 1'b0;
  localparam bit KIND_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_FLOOR = 2'd0,
    ST_WALL  = 2'd1,
    ST_WATER = 2'd2,
    ST_SPAWN = 2'd3
  } tile_state_e;

  typedef struct packed {
    logic [7:0] mask;
    logic [5:0] col;
    logic [9:0] row;
    logic       last;
    logic       done;
  } mask_beat_t;

  localparam mask_beat_t NO_MASK  = '0;
  localparam mask_beat_t LONE_MAP = '{8'hFF, 6'd0, 10'd0, 1'b1, 1'b1};

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_SET_WIDTH,
    ROW_SET_HEIGHT
  } plan_op_e;

  // typed rows carry their expected masks; the rest go to the predictor
  typedef struct packed {
    plan_op_e    op;
    logic        kind;
    logic [10:0] value;
    logic        typed;
    logic [1:0]  n;
    mask_beat_t  rec;
  } plan_row_t;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_ITEM,       KIND_FLUSH, 11'd0,    1'b1, 2'd0, NO_MASK},  // flush before map is in
    '{ROW_ITEM,       KIND_TILE,  ST_SPAWN, 1'b1, 2'd0, NO_MASK},  // first row gives nothing
    '{ROW_SET_WIDTH,  KIND_TILE,  11'd0,    1'b0, 2'd0, NO_MASK},  // zero acts as one
    '{ROW_SET_HEIGHT, KIND_TILE,  11'd0,    1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_SPAWN, 1'b1, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_WALL,  1'b1, 2'd0, NO_MASK},  // tile after map is in
    '{ROW_ITEM,       KIND_FLUSH, 11'd3,    1'b1, 2'd1, LONE_MAP},
    '{ROW_ITEM,       KIND_FLUSH, 11'd0,    1'b1, 2'd0, NO_MASK},  // map already restarted
    '{ROW_SET_WIDTH,  KIND_TILE,  11'd3,    1'b0, 2'd0, NO_MASK},
    '{ROW_SET_HEIGHT, KIND_TILE,  11'd3,    1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_FLOOR, 1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_FLOOR, 1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_WALL,  1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_FLUSH, 11'd2,    1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_WATER, 1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_FLOOR, 1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_SPAWN, 1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_FLOOR, 1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_WALL,  1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_WALL,  1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_SPAWN, 1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_FLUSH, 11'd1,    1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_FLUSH, 11'd0,    1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_FLUSH, 11'd3,    1'b0, 2'd0, NO_MASK},
    '{ROW_SET_WIDTH,  KIND_TILE,  11'd1,    1'b0, 2'd0, NO_MASK},  // single column
    '{ROW_SET_HEIGHT, KIND_TILE,  11'd2,    1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_SPAWN, 1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_TILE,  ST_SPAWN, 1'b0, 2'd0, NO_MASK},
    '{ROW_ITEM,       KIND_FLUSH, 11'd0,    1'b0, 2'd0, NO_MASK}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [1:0] tile_state
  logic [0:0]  in_tuser = '0;   // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [7:0] match_mask, [13:8] cell_column, [23:14] cell_row
  logic        out_tlast;
  logic [0:0]  out_tuser;       // [0] map_done
  logic        cfg_we = 1'b0;
  logic [tnm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [tnm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  tile_neighbor_match_mask dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow map and raster position
  logic [1:0]  grid [0:MAP_ROWS-1][0:MAP_COLS-1];
  logic [6:0]  width_reg = 7'd64;
  logic [10:0] height_reg = 11'd1024;
  int          next_col = 0;
  int          next_row = 0;
  int          drain_col = 0;
  bit          draining = 1'b0;
  int          dx [8] = '{0, 0, -1, 1, -1, 1, -1, 1};
  int          dy [8] = '{-1, 1, 0, 0, -1, -1, 1, 1};

  mask_beat_t  mask_due [$];
  mask_beat_t  beat_masks [$];
  bit          beat_used;
  int          items_taken = 0;
  int          errors = 0;
  int          quiet_cycles = 0;

  bit          tab_typed = 1'b0;
  int          tab_n = 0;
  mask_beat_t  tab_rec = '0;

  int          in_gap_pct = GAP_PCT;
  int          out_gap_pct = GAP_PCT;
  bit          hold_ask = 1'b0;
  int          hold_left = 0;

  function automatic int span_of(input int raw, input int top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return raw;
  endfunction

  function automatic void restart_map();
    next_col  = 0;
    next_row  = 0;
    drain_col = 0;
    draining  = 1'b0;
  endfunction

  function automatic mask_beat_t mask_at(input int r, input int c, input bit done);
    int         w;
    int         h;
    int         tx;
    int         ty;
    logic [1:0] self_st;
    mask_beat_t m;
    w       = span_of(width_reg, MAP_COLS);
    h       = span_of(height_reg, MAP_ROWS);
    self_st = grid[r][c];
    m       = '0;
    for (int i = 0; i < 8; i++) begin
      tx = c + dx[i];
      ty = r + dy[i];
      // off-map neighbours always match
      if (tx < 0 || tx >= w || ty < 0 || ty >= h) m.mask[i] = 1'b1;
      else if (grid[ty][tx] == self_st) m.mask[i] = 1'b1;
    end
    m.col  = c[5:0];
    m.row  = r[9:0];
    m.done = done;
    return m;
  endfunction

  task automatic predict_masks(input bit kind, input logic [1:0] st);
    int         w;
    int         h;
    bit         closing;
    mask_beat_t m;
    w = span_of(width_reg, MAP_COLS);
    h = span_of(height_reg, MAP_ROWS);
    beat_masks.delete();
    beat_used = 1'b0;
    if (kind == KIND_FLUSH) begin
      if (draining) begin
        beat_used = 1'b1;
        closing   = (drain_col >= w - 1);
        m         = mask_at(h - 1, drain_col, closing);
        m.last    = 1'b1;
        beat_masks.insert(beat_masks.size(), m);
        if (closing) restart_map();
        else drain_col++;
      end
    end else if (!draining) begin
      beat_used = 1'b1;
      grid[next_row][next_col] = st;
      if (next_row >= 1 && next_col >= 1)
        beat_masks.insert(beat_masks.size(), mask_at(next_row - 1, next_col - 1, 1'b0));
      if (next_row >= 1 && next_col == w - 1)
        beat_masks.insert(beat_masks.size(), mask_at(next_row - 1, next_col, 1'b0));
      if (beat_masks.size() > 0)
        beat_masks[beat_masks.size() - 1].last = 1'b1;
      if (next_col >= w - 1) begin
        next_col = 0;
        if (next_row >= h - 1) draining = 1'b1;
        else next_row++;
      end else begin
        next_col++;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // predict on every accepted input beat, check every accepted result beat
  always @(posedge clk) begin : scoreboard
    mask_beat_t got;
    mask_beat_t want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_addr == tnm_pkg::REG_MAP_WIDTH) width_reg = cfg_wdata[6:0];
        else height_reg = cfg_wdata[10:0];
        restart_map();
      end
      if (in_tvalid && in_tready) begin
        predict_masks(in_tuser[0], in_tdata[1:0]);
        if (beat_used) items_taken++;
        if (tab_typed) begin
          if (tab_n == 1) mask_due.insert(mask_due.size(), tab_rec);
        end else begin
          foreach (beat_masks[i]) mask_due.insert(mask_due.size(), beat_masks[i]);
        end
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[7:0], out_tdata[13:8], out_tdata[23:14], out_tlast, out_tuser[0]};
        if (mask_due.size() == 0) begin
          report_mismatch("result beat with nothing pending, row/col",
                          {got.row, got.col}, 0);
        end else begin
          want = mask_due.pop_front();
          if (got.mask != want.mask) report_mismatch("match_mask", got.mask, want.mask);
          if (got.col != want.col) report_mismatch("cell_column", got.col, want.col);
          if (got.row != want.row) report_mismatch("cell_row", got.row, want.row);
          if (got.last != want.last) report_mismatch("last_in_run", got.last, want.last);
          if (got.done != want.done) report_mismatch("map_done", got.done, want.done);
        end
      end
    end
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= out_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_beat(input bit kind, input logic [1:0] st, input bit typed,
                           input int n, input mask_beat_t rec);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    tab_typed = typed;
    tab_n     = n;
    tab_rec   = rec;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, st};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
  endtask

  // drop valid and let every pending result come out before touching a register
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (mask_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input tnm_pkg::cfg_reg_t which, input logic [10:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= which;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [1:0] pick_state();
    // lean towards two states so that matches are common
    if ($urandom_range(0, 99) < 50) return 2'($urandom_range(0, 1));
    return 2'($urandom_range(0, 3));
  endfunction

  function automatic int pick_width();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return $urandom_range(1, 6);
    if (p < 75) return $urandom_range(7, 16);
    if (p < 85) return MAP_COLS;
    if (p < 92) return 0;
    return $urandom_range(MAP_COLS + 1, 127);
  endfunction

  function automatic int pick_height();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return $urandom_range(1, 6);
    if (p < 80) return $urandom_range(7, 20);
    if (p < 88) return 0;
    if (p < 94) return MAP_ROWS;
    return $urandom_range(MAP_ROWS + 1, 2047);
  endfunction

  task automatic set_map(input int w_raw, input int h_raw);
    set_reg(tnm_pkg::REG_MAP_WIDTH, 11'(w_raw));
    set_reg(tnm_pkg::REG_MAP_HEIGHT, 11'(h_raw));
  endtask

  // whole map plus flushes, stray beats mixed in; with may_cut, large maps are cut short
  task automatic stream_map(input bit may_cut);
    int w;
    int cells;
    int total;
    int stop_at;
    w       = span_of(width_reg, MAP_COLS);
    cells   = w * span_of(height_reg, MAP_ROWS);
    total   = cells + w;
    stop_at = total;
    if (may_cut && (total > 260 || $urandom_range(0, 99) < 12))
      stop_at = $urandom_range(1, (total > 80) ? 80 : total - 1);
    for (int k = 0; k < stop_at; k++) begin
      if (k < cells) begin
        if ($urandom_range(0, 99) < 4)
          send_beat(KIND_FLUSH, 2'($urandom_range(0, 3)), 1'b0, 0, NO_MASK);
        send_beat(KIND_TILE, pick_state(), 1'b0, 0, NO_MASK);
      end else begin
        if ($urandom_range(0, 99) < 4)
          send_beat(KIND_TILE, pick_state(), 1'b0, 0, NO_MASK);
        send_beat(KIND_FLUSH, 2'($urandom_range(0, 3)), 1'b0, 0, NO_MASK);
      end
    end
  endtask

  initial begin : run
    int phase;
    phase = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      case (plan[i].op)
        ROW_SET_WIDTH: begin
          set_reg(tnm_pkg::REG_MAP_WIDTH, plan[i].value);
        end
        ROW_SET_HEIGHT: begin
          set_reg(tnm_pkg::REG_MAP_HEIGHT, plan[i].value);
        end
        default: begin
          send_beat(plan[i].kind, plan[i].value[1:0], plan[i].typed, plan[i].n, plan[i].rec);
        end
      endcase
    end

    while (items_taken < ITEMS_TARGET) begin
      in_gap_pct  = (phase % 5 == 1) ? 0 : GAP_PCT;
      out_gap_pct = (phase % 5 == 3) ? 0 : GAP_PCT;
      if (phase == 0) begin
        set_map(MAP_COLS, 2);
        stream_map(1'b0);
      end else if (phase == 2) begin
        // tallest map, single column, no idling on either side
        in_gap_pct  = 0;
        out_gap_pct = 0;
        set_map(1, MAP_ROWS);
        stream_map(1'b0);
      end else if (phase == 4) begin
        // hold the result side off while the input keeps coming
        set_map(8, 6);
        hold_ask = 1'b1;
        stream_map(1'b0);
      end else begin
        set_map(pick_width(), pick_height());
        stream_map(1'b1);
      end
      phase++;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (mask_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* tile_neighbor_match_mask.f */
+incdir+hw/rtl
hw/rtl/tnm_pkg.sv
hw/rtl/tnm_cell.sv
hw/rtl/tnm_line.sv
hw/rtl/tnm_out_q.sv
hw/rtl/tile_neighbor_match_mask.sv
hw/rtl/tnm_check.sv
sim/tb_tile_neighbor_match_mask.sv
